// ----- sv/pdf417_text_compaction_decoder_assert.svh -----
// Assertion macros shared by the checker
`ifndef PDF417_TEXT_COMPACTION_DECODER_ASSERT_SVH
`define PDF417_TEXT_COMPACTION_DECODER_ASSERT_SVH

// antecedent true -> consequent in the same cycle
`define TCD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcd assertion failed");

// antecedent true -> consequent in the following cycle
`define TCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcd assertion failed");

`endif

// ----- sv/tcd_pkg.sv -----
`default_nettype none

package tcd_pkg;

  typedef enum logic [2:0] {
    M_ALPHA  = 3'd0,
    M_LOWER  = 3'd1,
    M_MIXED  = 3'd2,
    M_PUNCT  = 3'd3,
    M_ASHIFT = 3'd4,
    M_PSHIFT = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    BS_NONE    = 2'd0,
    BS_EMIT    = 2'd1,
    BS_SWALLOW = 2'd2
  } bshift_t;

  localparam logic [9:0]  CW_LATCH_ALPHA = 10'd900;
  localparam logic [9:0]  CW_TERM_A      = 10'd901;
  localparam logic [9:0]  CW_TERM_B      = 10'd902;
  localparam logic [9:0]  CW_BYTE_SHIFT  = 10'd913;
  localparam logic [9:0]  CW_TERM_C      = 10'd922;
  localparam logic [9:0]  CW_TERM_D      = 10'd923;
  localparam logic [9:0]  CW_TERM_E      = 10'd924;
  localparam logic [9:0]  CW_TERM_F      = 10'd928;

  // floor(cw / 30) = (cw * 1093) >> 15 for cw below 900
  localparam logic [10:0] DIV30_MUL   = 11'd1093;
  localparam int          DIV30_SHIFT = 15;

  localparam logic [4:0]  SC_SPACE = 5'd26;
  localparam logic [4:0]  SC_27    = 5'd27;
  localparam logic [4:0]  SC_28    = 5'd28;
  localparam logic [4:0]  SC_25    = 5'd25;
  localparam logic [7:0]  CH_UPPER = 8'h41;
  localparam logic [7:0]  CH_LOWER = 8'h61;
  localparam logic [7:0]  CH_SPACE = 8'h20;

  typedef struct packed {
    mode_t      mode;
    mode_t      prior;
    logic       chv;
    logic [7:0] ch;
  } sub_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       seg;
  } pair_t;

  function automatic logic [7:0] punct_char(input logic [4:0] v);
    logic [7:0] c;
    case (v)
      5'd0:    c = 8'h3B;
      5'd1:    c = 8'h3C;
      5'd2:    c = 8'h3E;
      5'd3:    c = 8'h40;
      5'd4:    c = 8'h5B;
      5'd5:    c = 8'h5C;
      5'd6:    c = 8'h5D;
      5'd7:    c = 8'h5F;
      5'd8:    c = 8'h60;
      5'd9:    c = 8'h7E;
      5'd10:   c = 8'h21;
      5'd11:   c = 8'h0D;
      5'd12:   c = 8'h09;
      5'd13:   c = 8'h2C;
      5'd14:   c = 8'h3A;
      5'd15:   c = 8'h0A;
      5'd16:   c = 8'h2D;
      5'd17:   c = 8'h2E;
      5'd18:   c = 8'h24;
      5'd19:   c = 8'h2F;
      5'd20:   c = 8'h22;
      5'd21:   c = 8'h7C;
      5'd22:   c = 8'h2A;
      5'd23:   c = 8'h28;
      5'd24:   c = 8'h29;
      5'd25:   c = 8'h3F;
      5'd26:   c = 8'h7B;
      5'd27:   c = 8'h7D;
      5'd28:   c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mixed_char(input logic [4:0] v);
    logic [7:0] c;
    case (v)
      5'd0:    c = 8'h30;
      5'd1:    c = 8'h31;
      5'd2:    c = 8'h32;
      5'd3:    c = 8'h33;
      5'd4:    c = 8'h34;
      5'd5:    c = 8'h35;
      5'd6:    c = 8'h36;
      5'd7:    c = 8'h37;
      5'd8:    c = 8'h38;
      5'd9:    c = 8'h39;
      5'd10:   c = 8'h26;
      5'd11:   c = 8'h0D;
      5'd12:   c = 8'h09;
      5'd13:   c = 8'h2C;
      5'd14:   c = 8'h3A;
      5'd15:   c = 8'h23;
      5'd16:   c = 8'h2D;
      5'd17:   c = 8'h2E;
      5'd18:   c = 8'h24;
      5'd19:   c = 8'h2F;
      5'd20:   c = 8'h2B;
      5'd21:   c = 8'h25;
      5'd22:   c = 8'h2A;
      5'd23:   c = 8'h3D;
      5'd24:   c = 8'h5E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tcd_sub_dec.sv -----
`default_nettype none

// One base-30 subcode through the current submode
module tcd_sub_dec (
  input  wire tcd_pkg::mode_t    mode,
  input  wire tcd_pkg::mode_t    prior,
  input  wire logic [4:0]        v,
  output tcd_pkg::sub_res_t      res
);
  import tcd_pkg::*;

  always_comb begin
    res.mode  = mode;
    res.prior = prior;
    res.chv   = 1'b0;
    res.ch    = 8'h00;
    unique case (mode)
      M_LOWER: begin
        if (v < SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = 8'(CH_LOWER + {3'b000, v});
        end else if (v == SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = CH_SPACE;
        end else if (v == SC_27) begin
          res.prior = M_LOWER;
          res.mode  = M_ASHIFT;
        end else if (v == SC_28) begin
          res.mode = M_MIXED;
        end else begin
          res.prior = M_LOWER;
          res.mode  = M_PSHIFT;
        end
      end
      M_MIXED: begin
        if (v < SC_25) begin
          res.chv = 1'b1;
          res.ch  = mixed_char(v);
        end else if (v == SC_25) begin
          res.mode = M_PUNCT;
        end else if (v == SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = CH_SPACE;
        end else if (v == SC_27) begin
          res.mode = M_LOWER;
        end else if (v == SC_28) begin
          res.mode = M_ALPHA;
        end else begin
          res.prior = M_MIXED;
          res.mode  = M_PSHIFT;
        end
      end
      M_PUNCT: begin
        if (v < 5'd29) begin
          res.chv = 1'b1;
          res.ch  = punct_char(v);
        end else begin
          res.mode = M_ALPHA;
        end
      end
      M_ASHIFT: begin
        res.mode = prior;
        if (v < SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = 8'(CH_UPPER + {3'b000, v});
        end else if (v == SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = CH_SPACE;
        end
      end
      M_PSHIFT: begin
        if (v < 5'd29) begin
          res.mode = prior;
          res.chv  = 1'b1;
          res.ch   = punct_char(v);
        end else begin
          res.mode = M_ALPHA;
        end
      end
      default: begin
        res.mode = M_ALPHA;
        if (v < SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = 8'(CH_UPPER + {3'b000, v});
        end else if (v == SC_SPACE) begin
          res.chv = 1'b1;
          res.ch  = CH_SPACE;
        end else if (v == SC_27) begin
          res.mode = M_LOWER;
        end else if (v == SC_28) begin
          res.mode = M_MIXED;
        end else begin
          res.prior = M_ALPHA;
          res.mode  = M_PSHIFT;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tcd_out_buf.sv -----
`default_nettype none

// Holds up to two characters of one codeword and hands them out one a cycle while m_tready is high
module tcd_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire tcd_pkg::pair_t pair_in,
  output logic               can_load,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [15:0]        m_tdata,   // [7:0] char_out, [8] seg_end, [15:9] zero
  output logic               m_tlast
);
  import tcd_pkg::*;

  logic [1:0] cnt;
  logic [7:0] ch0;
  logic [7:0] ch1;
  logic       seg;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tlast  = (cnt == 2'd1);
  assign m_tdata  = {7'b0, seg, ch0};
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= pair_in.cnt;
    end else if (m_tvalid && m_tready) begin
      cnt <= 2'(cnt - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch0 <= pair_in.ch0;
      ch1 <= pair_in.ch1;
      seg <= pair_in.seg;
    end else if (m_tvalid && m_tready) begin
      ch0 <= ch1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pdf417_text_compaction_decoder.sv -----
`default_nettype none

// PDF417 text compaction decoder. One codeword enters per s_tdata transaction
// (s_tuser flags the first codeword of a text segment) and its characters
// leave one per m_tdata transaction, with m_tlast on the final character of
// that codeword; a terminating codeword gives one transaction with seg_end
// set and a zero character. Codewords yielding no character leave nothing.
// The block takes a codeword every cycle while m_tready is high and each gives
// at most one character; a codeword that gives two characters holds the input
// until its first character has left, as the result port carries one character
// per cycle. The codeword is registered, decoded in one pass through both
// subcodes, and the characters land in a two-entry result register.
module pdf417_text_compaction_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] codeword, [15:10] zero
  input  wire logic        s_tuser,   // [0] segment_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] char_out, [8] seg_end, [15:9] zero
  output logic             m_tlast
);
  import tcd_pkg::*;

  logic       in_valid;
  logic [9:0] in_cw;
  logic       in_start;

  mode_t      sub_mode, sub_mode_next;
  mode_t      prior_mode, prior_mode_next;
  bshift_t    byte_shift, byte_shift_next;
  logic       active, active_next;

  logic       can_load;
  logic       load;
  pair_t      pair;

  mode_t      m0;
  mode_t      p0;
  bshift_t    bs0;
  logic       act0;
  logic [19:0] prod;
  logic [4:0] hi;
  logic [4:0] lo;
  sub_res_t   r_hi;
  sub_res_t   r_lo;
  logic       is_term;

  assign s_tready = !in_valid || can_load;
  assign load     = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cw    <= s_tdata[9:0];
      in_start <= s_tuser;
    end
  end

  assign prod = 20'(in_cw) * 20'(DIV30_MUL);
  assign hi   = prod[DIV30_SHIFT +: 5];
  assign lo   = 5'(in_cw - 10'(hi) * 10'd30);

  assign m0   = in_start ? M_ALPHA : sub_mode;
  assign p0   = in_start ? M_ALPHA : prior_mode;
  assign bs0  = in_start ? BS_NONE : byte_shift;
  assign act0 = in_start || active;

  assign is_term = (in_cw == CW_TERM_A) || (in_cw == CW_TERM_B) ||
                   (in_cw == CW_TERM_C) || (in_cw == CW_TERM_D) ||
                   (in_cw == CW_TERM_E) || (in_cw == CW_TERM_F);

  tcd_sub_dec u_dec_hi (
    .mode  (m0),
    .prior (p0),
    .v     (hi),
    .res   (r_hi)
  );

  tcd_sub_dec u_dec_lo (
    .mode  (r_hi.mode),
    .prior (r_hi.prior),
    .v     (lo),
    .res   (r_lo)
  );

  always_comb begin
    sub_mode_next   = m0;
    prior_mode_next = p0;
    byte_shift_next = bs0;
    active_next     = act0;
    pair.cnt        = 2'd0;
    pair.ch0        = 8'h00;
    pair.ch1        = 8'h00;
    pair.seg        = 1'b0;
    if (!act0) begin
      pair.cnt = 2'd0;
    end else if (bs0 != BS_NONE) begin
      byte_shift_next = BS_NONE;
      if (bs0 != BS_SWALLOW) begin
        pair.cnt = 2'd1;
        pair.ch0 = in_cw[7:0];
      end
    end else if (in_cw < CW_LATCH_ALPHA) begin
      sub_mode_next   = r_lo.mode;
      prior_mode_next = r_lo.prior;
      pair.cnt        = 2'({1'b0, r_hi.chv} + {1'b0, r_lo.chv});
      pair.ch0        = r_hi.chv ? r_hi.ch : r_lo.ch;
      pair.ch1        = r_lo.ch;
    end else if (in_cw == CW_LATCH_ALPHA) begin
      sub_mode_next = M_ALPHA;
    end else if (in_cw == CW_BYTE_SHIFT) begin
      if (m0 == M_ASHIFT) begin
        sub_mode_next   = p0;
        byte_shift_next = BS_SWALLOW;
      end else begin
        if (m0 == M_PSHIFT) begin
          sub_mode_next = p0;
        end
        byte_shift_next = BS_EMIT;
      end
    end else if (is_term) begin
      active_next = 1'b0;
      pair.cnt    = 2'd1;
      pair.seg    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_mode   <= M_ALPHA;
      prior_mode <= M_ALPHA;
      byte_shift <= BS_NONE;
      active     <= 1'b0;
    end else if (load) begin
      sub_mode   <= sub_mode_next;
      prior_mode <= prior_mode_next;
      byte_shift <= byte_shift_next;
      active     <= active_next;
    end
  end

  tcd_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .pair_in  (pair),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- sv/tcd_checker.sv -----
`default_nettype none

`include "pdf417_text_compaction_decoder_assert.svh"

module tcd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // end-of-segment transaction is alone and carries no character
  `TCD_ASSERT_SAME(a_seg_end_clean, clk, rst, m_tvalid && m_tdata[8], (m_tdata[7:0] == 8'h00) && m_tlast)

  `TCD_ASSERT_SAME(a_pad_zero, clk, rst, m_tvalid, m_tdata[15:9] == 7'b0)

  // second character of a codeword follows straight on
  `TCD_ASSERT_NEXT(a_pair_follows, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)

  `TCD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind pdf417_text_compaction_decoder tcd_checker u_tcd_checker (.*);

`default_nettype wire

// ----- bench/tb_pdf417_text_compaction_decoder.sv -----
module tb_pdf417_text_compaction_decoder;
  import tcd_pkg::*;

  localparam int RANDOM_ITEMS   = 550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PAUSE_SEG      = 15;
  localparam int QUIET_SEG      = 25;
  localparam logic [4:0] SC_29  = 5'd29;

  // character sets, entry 0 in the top byte
  localparam logic [8*29-1:0] PUNCT_SET = {
    8'h3B, 8'h3C, 8'h3E, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5F, 8'h60, 8'h7E,
    8'h21, 8'h0D, 8'h09, 8'h2C, 8'h3A, 8'h0A, 8'h2D, 8'h2E, 8'h24, 8'h2F,
    8'h22, 8'h7C, 8'h2A, 8'h28, 8'h29, 8'h3F, 8'h7B, 8'h7D, 8'h27};
  localparam logic [8*25-1:0] MIXED_SET = {
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h26, 8'h0D, 8'h09, 8'h2C, 8'h3A, 8'h23, 8'h2D, 8'h2E, 8'h24, 8'h2F,
    8'h2B, 8'h25, 8'h2A, 8'h3D, 8'h5E};

  typedef struct packed {
    logic [7:0] ch;
    logic       seg;
    logic       last;
  } char_exp_t;

  typedef struct packed {
    logic [9:0] cw;
    logic       start;
    logic       typed;
    logic [1:0] n;
    logic [8:0] r0;
    logic [8:0] r1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  pdf417_text_compaction_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder state
  mode_t     cur_mode = M_ALPHA;
  mode_t     ret_mode = M_ALPHA;
  bshift_t   pend     = BS_NONE;
  bit        seg_on   = 1'b0;

  char_exp_t expected_chars [$];
  char_exp_t want;
  dir_row_t  dir_rows [$];
  int        mismatches   = 0;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        segments     = 0;
  int        idle_cycles  = 0;
  int        rx_hold      = 0;
  int        rx_gap;
  bit        quiet        = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit sub_char(input logic [4:0] v, output logic [7:0] ch);
    ch = 8'h00;
    case (cur_mode)
      M_LOWER: begin
        if (v < SC_SPACE) begin
          ch = CH_LOWER + v;
          return 1'b1;
        end
        if (v == SC_SPACE) begin
          ch = CH_SPACE;
          return 1'b1;
        end
        if (v == SC_27) begin
          ret_mode = M_LOWER;
          cur_mode = M_ASHIFT;
        end else if (v == SC_28) begin
          cur_mode = M_MIXED;
        end else begin
          ret_mode = M_LOWER;
          cur_mode = M_PSHIFT;
        end
      end
      M_MIXED: begin
        if (v < SC_25) begin
          ch = MIXED_SET[8*(24-v) +: 8];
          return 1'b1;
        end
        if (v == SC_25) begin
          cur_mode = M_PUNCT;
        end else if (v == SC_SPACE) begin
          ch = CH_SPACE;
          return 1'b1;
        end else if (v == SC_27) begin
          cur_mode = M_LOWER;
        end else if (v == SC_28) begin
          cur_mode = M_ALPHA;
        end else begin
          ret_mode = M_MIXED;
          cur_mode = M_PSHIFT;
        end
      end
      M_PUNCT: begin
        if (v < SC_29) begin
          ch = PUNCT_SET[8*(28-v) +: 8];
          return 1'b1;
        end
        cur_mode = M_ALPHA;
      end
      M_ASHIFT: begin
        cur_mode = ret_mode;
        if (v < SC_SPACE) begin
          ch = CH_UPPER + v;
          return 1'b1;
        end
        if (v == SC_SPACE) begin
          ch = CH_SPACE;
          return 1'b1;
        end
      end
      M_PSHIFT: begin
        cur_mode = ret_mode;
        if (v < SC_29) begin
          ch = PUNCT_SET[8*(28-v) +: 8];
          return 1'b1;
        end
        cur_mode = M_ALPHA;
      end
      default: begin
        cur_mode = M_ALPHA;
        if (v < SC_SPACE) begin
          ch = CH_UPPER + v;
          return 1'b1;
        end
        if (v == SC_SPACE) begin
          ch = CH_SPACE;
          return 1'b1;
        end
        if (v == SC_27) begin
          cur_mode = M_LOWER;
        end else if (v == SC_28) begin
          cur_mode = M_MIXED;
        end else begin
          ret_mode = M_ALPHA;
          cur_mode = M_PSHIFT;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // results as {seg_end, char}; returns how many the codeword gives
  function automatic int decode_codeword(input logic [9:0] cw, input bit start,
                                         output logic [8:0] r0, output logic [8:0] r1);
    int n;
    logic [7:0] ch;
    n = 0;
    r0 = 9'h000;
    r1 = 9'h000;
    if (start) begin
      cur_mode = M_ALPHA;
      ret_mode = M_ALPHA;
      pend = BS_NONE;
      seg_on = 1'b1;
    end
    if (!seg_on) return 0;
    if (pend != BS_NONE) begin
      if (pend == BS_SWALLOW) begin
        pend = BS_NONE;
        return 0;
      end
      pend = BS_NONE;
      r0 = {1'b0, cw[7:0]};
      return 1;
    end
    if (cw < CW_LATCH_ALPHA) begin
      if (sub_char(5'(cw / 10'd30), ch)) begin
        r0 = {1'b0, ch};
        n = 1;
      end
      if (sub_char(5'(cw % 10'd30), ch)) begin
        if (n == 0) r0 = {1'b0, ch};
        else r1 = {1'b0, ch};
        n = n + 1;
      end
    end else if (cw == CW_LATCH_ALPHA) begin
      cur_mode = M_ALPHA;
    end else if (cw == CW_BYTE_SHIFT) begin
      if (cur_mode == M_ASHIFT) begin
        cur_mode = ret_mode;
        pend = BS_SWALLOW;
      end else begin
        if (cur_mode == M_PSHIFT) cur_mode = ret_mode;
        pend = BS_EMIT;
      end
    end else if (cw == CW_TERM_A || cw == CW_TERM_B || cw == CW_TERM_C ||
                 cw == CW_TERM_D || cw == CW_TERM_E || cw == CW_TERM_F) begin
      seg_on = 1'b0;
      r0 = 9'h100;
      n = 1;
    end
    return n;
  endfunction

  function automatic logic [9:0] term_cw();
    case ($urandom_range(0, 5))
      0:       return CW_TERM_A;
      1:       return CW_TERM_B;
      2:       return CW_TERM_C;
      3:       return CW_TERM_D;
      4:       return CW_TERM_E;
      default: return CW_TERM_F;
    endcase
  endfunction

  function automatic logic [9:0] pick_body();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return 10'($urandom_range(0, 899));
    // high subcodes 25 to 29, where most submode changes lie
    if (r < 72) return 10'($urandom_range(25, 29) * 30 + $urandom_range(0, 29));
    if (r < 77) return CW_LATCH_ALPHA;
    if (r < 84) return CW_BYTE_SHIFT;
    if (r < 90) return term_cw();
    return 10'($urandom_range(903, 1023));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic send_codeword(input logic [9:0] cw, input bit start, input bit typed,
                               input logic [1:0] tn, input logic [8:0] t0,
                               input logic [8:0] t1);
    int n;
    int g;
    logic [8:0] p0;
    logic [8:0] p1;
    char_exp_t e;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, cw};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    n = decode_codeword(cw, start, p0, p1);
    if (typed) begin
      n  = tn;
      p0 = t0;
      p1 = t1;
    end
    if (n >= 1) begin
      e = '{ch: p0[7:0], seg: p0[8], last: (n == 1)};
      expected_chars.push_back(e);
    end
    if (n >= 2) begin
      e = '{ch: p1[7:0], seg: p1[8], last: 1'b1};
      expected_chars.push_back(e);
    end
    items_sent++;
    if (!quiet) begin
      g = gap_len();
      if (g > 0) begin
        s_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected result: data %h last %b", m_tdata, m_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== {7'b0, want.seg, want.ch} || m_tlast !== want.last)
          note_mismatch($sformatf(
            "result %0d: char exp %h got %h, seg_end exp %b got %b, last exp %b got %b, pad %h",
            results_seen, want.ch, m_tdata[7:0], want.seg, m_tdata[8], want.last,
            m_tlast, m_tdata[15:9]));
      end
    end
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      rx_gap = gap_len();
      if (rx_gap > 0) begin
        rx_hold  <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_chars.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int len;
    // cw, segment_start, typed, count, {seg_end, char} x2
    dir_rows = '{
      '{10'd0,    1'b0, 1'b1, 2'd0, 9'h000, 9'h000},  // idle after reset
      '{10'd928,  1'b0, 1'b1, 2'd0, 9'h000, 9'h000},
      '{10'd0,    1'b1, 1'b1, 2'd2, 9'h041, 9'h041},
      '{10'd899,  1'b0, 1'b1, 2'd0, 9'h000, 9'h000},  // shift to punct, then back
      '{10'd836,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd25,   1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd840,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd746,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd756,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},  // punct bracket entry
      '{10'd869,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd837,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd913,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},  // byte under alpha shift
      '{10'd65,   1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd875,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd869,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd913,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},  // byte under punct shift
      '{10'd1023, 1'b0, 1'b1, 2'd1, 9'h0FF, 9'h000},
      '{10'd913,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd901,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},  // terminator taken as byte
      '{10'd900,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd929,  1'b0, 1'b1, 2'd0, 9'h000, 9'h000},
      '{10'd808,  1'b0, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd902,  1'b0, 1'b1, 2'd1, 9'h100, 9'h000},
      '{10'd913,  1'b1, 1'b0, 2'd0, 9'h000, 9'h000},
      '{10'd0,    1'b1, 1'b0, 2'd0, 9'h000, 9'h000},  // start drops pending byte
      '{10'd923,  1'b1, 1'b1, 2'd1, 9'h100, 9'h000}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_codeword(dir_rows[i].cw, dir_rows[i].start, dir_rows[i].typed,
                    dir_rows[i].n, dir_rows[i].r0, dir_rows[i].r1);

    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      segments++;
      if (segments == PAUSE_SEG) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_chars.size() != 0);
      end
      quiet = (segments >= QUIET_SEG && segments < QUIET_SEG + 2);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_codeword(pick_body(), 1'b0, 1'b0, 2'd0, 9'h0, 9'h0);
      end else begin
        len = $urandom_range(2, 24);
        send_codeword(pick_body(), 1'b1, 1'b0, 2'd0, 9'h0, 9'h0);
        repeat (len)
          send_codeword(pick_body(), ($urandom_range(0, 39) == 0), 1'b0, 2'd0, 9'h0, 9'h0);
        if ($urandom_range(0, 9) != 0)
          send_codeword(term_cw(), 1'b0, 1'b0, 2'd0, 9'h0, 9'h0);
      end
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d codewords (%0d directed) over %0d random segments", items_sent,
             dir_rows.size(), segments);
    $display("Checked %0d characters and segment ends, %0d mismatches", results_seen,
             mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
